[rtl/isms_pkg.sv]
// Shared constants, types and bit-search helpers for the interval split / max gap block.
// No dependencies; every other file in rtl/ except isms_ram.sv imports this package.
package isms_pkg;

    // Width of every field on the ports.
    localparam int FIELD_W = 13;
    // The cut bitmap is stored as words of 2**BIT_W positions.
    localparam int BIT_W   = 6;
    localparam int WORD_W  = 64;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BIT_W-1:0]   bit_idx_t;

    // One result item as the engine hands it to the output channel.
    typedef struct packed {
        field_t longest_gap;
        logic   rejected;
    } gap_item_t;

    // Index of the highest set bit; zero for an empty word.
    function automatic bit_idx_t msb_index(input word_t w);
        bit_idx_t idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                idx = bit_idx_t'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit; zero for an empty word.
    function automatic bit_idx_t lsb_index(input word_t w);
        bit_idx_t idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = bit_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/isms_if.sv]
// Valid/ready channel interfaces for the cut input, the result output and the length register.
// Depends on isms_pkg for the field width.
interface isms_cut_if;
    import isms_pkg::*;
    logic   valid;
    logic   ready;
    field_t cut_position;
    modport source (output valid, output cut_position, input ready);
    modport sink   (input valid, input cut_position, output ready);
endinterface

interface isms_gap_if;
    import isms_pkg::*;
    logic   valid;
    logic   ready;
    field_t longest_gap;
    logic   rejected;
    modport source (output valid, output longest_gap, output rejected, input ready);
    modport sink   (input valid, input longest_gap, input rejected, output ready);
endinterface

interface isms_cfg_if;
    import isms_pkg::*;
    logic   valid;
    logic   ready;
    field_t line_length;
    modport source (output valid, output line_length, input ready);
    modport sink   (input valid, input line_length, output ready);
endinterface

[rtl/isms_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module isms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/isms_engine.sv]
// Sequencer that owns the cut bitmap and the gap histogram memories and processes one cut.
// Depends on isms_pkg and isms_ram.
module isms_engine #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]   len,
    input  logic                              in_valid,
    input  isms_pkg::field_t                  in_pos,
    output logic                              in_ready,
    output logic                              out_valid,
    output isms_pkg::gap_item_t               out_data,
    input  logic                              out_ready
);
    import isms_pkg::*;

    localparam int HAW    = $clog2(MAX_LENGTH + 1);
    localparam int HDEPTH = MAX_LENGTH + 1;
    localparam int PW     = (HAW > BIT_W + 1) ? HAW : BIT_W + 1;
    localparam int NWORDS = (MAX_LENGTH + WORD_W - 1) / WORD_W;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int XW     = (PW > FIELD_W) ? PW : FIELD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_LSCAN, S_RSCAN,
        S_HRD, S_HWR, S_WRD, S_WCHK, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_DEC, OP_INC_L, OP_INC_R
    } op_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [HAW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic              started_reg, started_next;
    logic [HAW-1:0]    max_reg, max_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     left_reg, left_next;
    logic [PW-1:0]     right_reg, right_next;
    logic [WIW-1:0]    lw_reg, lw_next;
    logic [WIW-1:0]    rw_reg, rw_next;
    logic              rfound_reg, rfound_next;
    logic              rej_reg, rej_next;
    word_t             word_reg, word_next;
    logic              out_valid_reg, out_valid_next;
    gap_item_t         out_data_reg, out_data_next;

    logic              bm_we;
    logic [WIW-1:0]    bm_waddr, bm_raddr;
    word_t             bm_wdata, bm_rdata;
    logic              hist_we;
    logic [HAW-1:0]    hist_waddr, hist_raddr, hist_wdata, hist_rdata;

    isms_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_cut_map (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    isms_ram #(.WIDTH(HAW), .DEPTH(HDEPTH)) u_gap_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        word_t          bit_sel;
        word_t          lo_mask;
        word_t          hi_mask;
        word_t          lo_bits;
        word_t          hi_bits;
        logic [WIW-1:0] pos_word;
        logic [WIW-1:0] last_word;
        logic [PW-1:0]  whole;
        logic [PW-1:0]  gap_l;
        logic [PW-1:0]  gap_r;
        logic [HAW-1:0] op_addr;
        logic [XW-1:0]  pos_x;
        logic [XW-1:0]  len_x;
        logic           ldone;
        logic           enter_hist;

        state_next     = state_reg;
        op_next        = op_reg;
        clr_cnt_next   = clr_cnt_reg;
        started_next   = started_reg;
        max_next       = max_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        lw_next        = lw_reg;
        rw_next        = rw_reg;
        rfound_next    = rfound_reg;
        rej_next       = rej_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ldone          = 1'b0;
        enter_hist     = 1'b0;

        pos_word  = WIW'(pos_reg >> BIT_W);
        last_word = WIW'((PW'(len) - PW'(1)) >> BIT_W);
        bit_sel   = word_t'(1) << pos_reg[BIT_W-1:0];
        lo_mask   = bit_sel - word_t'(1);
        hi_mask   = ~(lo_mask | bit_sel);
        lo_bits   = bm_rdata & lo_mask;
        hi_bits   = bm_rdata & hi_mask;
        whole     = right_reg - left_reg;
        gap_l     = pos_reg - left_reg;
        gap_r     = right_reg - pos_reg;
        pos_x     = XW'(in_pos);
        len_x     = XW'(len);

        case (op_reg)
            OP_DEC:   op_addr = HAW'(whole);
            OP_INC_L: op_addr = HAW'(gap_l);
            default:  op_addr = HAW'(gap_r);
        endcase

        bm_we      = 1'b0;
        bm_waddr   = pos_word;
        bm_wdata   = word_reg;
        bm_raddr   = pos_word;
        hist_we    = 1'b0;
        hist_waddr = op_addr;
        hist_wdata = '0;
        hist_raddr = op_addr;

        case (state_reg)
            S_CLEAR:
            begin
                bm_we      = clr_cnt_reg < HAW'(NWORDS);
                bm_waddr   = WIW'(clr_cnt_reg);
                bm_wdata   = '0;
                hist_we    = 1'b1;
                hist_waddr = clr_cnt_reg;
                hist_wdata = '0;
                if (clr_cnt_reg == HAW'(MAX_LENGTH))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + HAW'(1);
                end
            end

            S_IDLE:
            begin
                bm_raddr = WIW'(PW'(in_pos) >> BIT_W);
                if (in_valid)
                begin
                    pos_next = PW'(in_pos);
                    if (pos_x != '0 && pos_x < len_x)
                    begin
                        rej_next   = 1'b0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        rej_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_CHECK:
            begin
                if ((bm_rdata & bit_sel) != '0)
                begin
                    rej_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    word_next = bm_rdata | bit_sel;
                    lw_next   = pos_word - WIW'(1);
                    rw_next   = pos_word + WIW'(1);
                    if (lo_bits != '0)
                    begin
                        left_next = PW'({pos_word, msb_index(lo_bits)});
                        ldone     = 1'b1;
                    end
                    else if (pos_word == '0)
                    begin
                        left_next = '0;
                        ldone     = 1'b1;
                    end
                    if (hi_bits != '0)
                    begin
                        right_next  = PW'({pos_word, lsb_index(hi_bits)});
                        rfound_next = 1'b1;
                    end
                    else if (pos_word == last_word)
                    begin
                        right_next  = PW'(len);
                        rfound_next = 1'b1;
                    end
                    else
                    begin
                        rfound_next = 1'b0;
                    end
                    if (!ldone)
                    begin
                        bm_raddr   = pos_word - WIW'(1);
                        state_next = S_LSCAN;
                    end
                    else if (!rfound_next)
                    begin
                        bm_raddr   = pos_word + WIW'(1);
                        state_next = S_RSCAN;
                    end
                    else
                    begin
                        enter_hist = 1'b1;
                    end
                end
            end

            S_LSCAN:
            begin
                // The word at lw_reg was read in the previous cycle.
                if (bm_rdata != '0)
                begin
                    left_next = PW'({lw_reg, msb_index(bm_rdata)});
                    ldone     = 1'b1;
                end
                else if (lw_reg == '0)
                begin
                    left_next = '0;
                    ldone     = 1'b1;
                end
                else
                begin
                    lw_next  = lw_reg - WIW'(1);
                    bm_raddr = lw_reg - WIW'(1);
                end
                if (ldone)
                begin
                    if (rfound_reg)
                    begin
                        enter_hist = 1'b1;
                    end
                    else
                    begin
                        bm_raddr   = rw_reg;
                        state_next = S_RSCAN;
                    end
                end
            end

            S_RSCAN:
            begin
                if (bm_rdata != '0)
                begin
                    right_next = PW'({rw_reg, lsb_index(bm_rdata)});
                    enter_hist = 1'b1;
                end
                else if (rw_reg == last_word)
                begin
                    right_next = PW'(len);
                    enter_hist = 1'b1;
                end
                else
                begin
                    rw_next  = rw_reg + WIW'(1);
                    bm_raddr = rw_reg + WIW'(1);
                end
            end

            S_HRD:
            begin
                // Store the new cut while the histogram is being updated.
                bm_we      = 1'b1;
                state_next = S_HWR;
            end

            S_HWR:
            begin
                hist_we = 1'b1;
                if (op_reg == OP_DEC)
                begin
                    hist_wdata = (hist_rdata == '0) ? '0 : hist_rdata - HAW'(1);
                end
                else
                begin
                    hist_wdata = hist_rdata + HAW'(1);
                end
                if (op_reg == OP_INC_R)
                begin
                    state_next = (HAW'(whole) == max_reg) ? S_WRD : S_DONE;
                end
                else
                begin
                    op_next    = (op_reg == OP_DEC) ? OP_INC_L : OP_INC_R;
                    state_next = S_HRD;
                end
            end

            S_WRD:
            begin
                hist_raddr = max_reg;
                state_next = S_WCHK;
            end

            S_WCHK:
            begin
                // Walk down one length a cycle until a populated bin turns up.
                if (hist_rdata != '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    max_next   = max_reg - HAW'(1);
                    hist_raddr = max_reg - HAW'(1);
                    if (max_reg == HAW'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.longest_gap = FIELD_W'(started_reg ? max_reg : len);
                    out_data_next.rejected    = rej_reg;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (enter_hist)
        begin
            state_next = S_HRD;
            // The first cut turns the whole line into one gap and splits it at once,
            // so that bin ends at zero and the decrement is skipped.
            if (started_reg)
            begin
                op_next = OP_DEC;
            end
            else
            begin
                op_next      = OP_INC_L;
                started_next = 1'b1;
                max_next     = len;
            end
        end

        if (clear)
        begin
            state_next   = S_CLEAR;
            clr_cnt_next = '0;
            started_next = 1'b0;
            max_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_DEC;
            clr_cnt_reg   <= '0;
            started_reg   <= 1'b0;
            max_reg       <= '0;
            pos_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            lw_reg        <= '0;
            rw_reg        <= '0;
            rfound_reg    <= 1'b0;
            rej_reg       <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            clr_cnt_reg   <= clr_cnt_next;
            started_reg   <= started_next;
            max_reg       <= max_next;
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            lw_reg        <= lw_next;
            rw_reg        <= rw_next;
            rfound_reg    <= rfound_next;
            rej_reg       <= rej_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/interval_split_max_gap_core.sv]
// Top level of the interval split / max gap block: length register and channel wiring.
// Depends on isms_pkg, the interfaces in isms_if.sv and isms_engine.
//
// Usage: cut_in carries one cut position per transfer; gap_out returns exactly one
// result per cut (longest gap after the cut, and a rejected flag for a position that
// is zero, at or past the line length, or already cut). cfg writes the line length;
// every write starts the line fresh and restarts the clearing sweep. cfg.ready is
// always high. Lengths above MAX_LENGTH are treated as MAX_LENGTH.
// A position that is zero or at or past the length goes straight to the result; else
// its bitmap word is read and a position already cut is rejected. A new cut finds its
// neighbours in its own 64-bit word or in further words searched on either side, then
// updates the histogram (decrementing the split gap's bin, except for the first cut on
// a fresh line, and incrementing the two new gaps' bins), and steps the maximum down
// when the split gap was the longest. The next cut can be accepted in the cycle after
// the result is loaded; one cut is in flight. Reset, and every length write, runs a
// clearing sweep over both memories with cut_in.ready low. A result waits in the
// output register while gap_out.ready is low; the next cut is still accepted and
// held back only when it completes before the pending result has been taken.
module interval_split_max_gap_core #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    isms_cut_if.sink    cut_in,
    isms_gap_if.source  gap_out,
    isms_cfg_if.sink    cfg
);
    import isms_pkg::*;

    localparam int HAW = $clog2(MAX_LENGTH + 1);
    localparam int XW  = (HAW > FIELD_W) ? HAW : FIELD_W;

    field_t          line_length_reg;
    logic [HAW-1:0]  eff_len;
    gap_item_t       result;

    // The length register accepts a write in any cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= FIELD_W'(4096);
        end
        else if (cfg.valid)
        begin
            line_length_reg <= cfg.line_length;
        end
    end

    assign cfg.ready = 1'b1;

    // Saturate the programmed length to what the memories can hold.
    assign eff_len = (XW'(line_length_reg) > XW'(MAX_LENGTH)) ? HAW'(MAX_LENGTH)
                                                              : HAW'(line_length_reg);

    isms_engine #(.MAX_LENGTH(MAX_LENGTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg.valid),
        .len       (eff_len),
        .in_valid  (cut_in.valid),
        .in_pos    (cut_in.cut_position),
        .in_ready  (cut_in.ready),
        .out_valid (gap_out.valid),
        .out_data  (result),
        .out_ready (gap_out.ready)
    );

    assign gap_out.longest_gap = result.longest_gap;
    assign gap_out.rejected    = result.rejected;

`ifndef ASSERT_OFF
    // A length write always starts a clearing sweep, so no cut can follow at once.
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !cut_in.ready)
        else $error("cut accepted right after a length write");

    // Only one cut is processed at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cut_in.valid && cut_in.ready |=> !cut_in.ready)
        else $error("second cut accepted while one is in flight");

    // No result can appear in the cycle right after a cut is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cut_in.valid && cut_in.ready |=> !$rose(gap_out.valid))
        else $error("result appeared too early after a cut");
`endif

endmodule
